[rtl/core/agenv_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Attack/release gain envelope package
// Shared widths, codes, controller/datapath interface types and the
// quarter-wave sine table used by the constant power curve.
// ----------------------------------------------------------------------------
package agenv_pkg;

    localparam int SAMPLE_BITS  = 24;
    // The table depth must be a power of two; the table index is a bit slice
    // of the progress fraction.
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_ABITS   = $clog2(SINE_ENTRIES);

    localparam int Q_BITS    = 24;
    localparam int GAIN_W    = Q_BITS + 1;
    localparam int LEN_W     = 24;
    localparam int RECIP_W   = 25;
    localparam int POS_W     = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 2;
    localparam int CURVE_W   = 2;

    localparam int MUL_W  = (SAMPLE_BITS > GAIN_W) ? SAMPLE_BITS : GAIN_W;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [GAIN_W-1:0] ONE_Q24  = {1'b1, {Q_BITS{1'b0}}};
    localparam logic [GAIN_W-1:0] HALF_Q24 = {2'b01, {(Q_BITS-1){1'b0}}};

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_SAMPLE  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // Ramp curve codes.
    localparam logic [CURVE_W-1:0] CURVE_SQUARED = 2'd0;
    localparam logic [CURVE_W-1:0] CURVE_LINEAR  = 2'd1;
    localparam logic [CURVE_W-1:0] CURVE_SINE    = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_START   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RECIP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_START  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LENGTH = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RECIP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_CURVE     = 3'd6;

    typedef enum logic [1:0] {
        MUL_PROG,
        MUL_SQR,
        MUL_INTERP,
        MUL_SCALE
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        logic     region_load;
        mul_sel_t mul_sel;
        logic     mul_load;
        logic     clamp_load;
        logic     rom_hi;
        logic     lo_load;
        logic     delta_load;
        logic     gain_load;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic               ramp;
        logic [CURVE_W-1:0] curve;
        logic               out_full;
    } sts_t;

    typedef logic [Q_BITS-1:0] sine_tab_t [SINE_ENTRIES];

    // Long division by shift and subtract; it only runs while the table is built.
    function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
        longint unsigned q;
        longint unsigned rem;
        q   = 0;
        rem = 0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], n[b]};
            if (rem >= d)
            begin
                rem  = rem - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Entry i = sin(pi/2 * i / SINE_ENTRIES) in Q0.24, from a Taylor series
    // evaluated in Q30.
    function automatic logic [Q_BITS-1:0] sine_q24(int unsigned i);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned r;
        longint unsigned div;
        longint          sum;
        int unsigned     k;
        x    = (longint'(i) * HALF_PI_Q30) >> SINE_ABITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (k = 1; k <= 7; k++)
        begin
            div  = longint'((2 * k) * (2 * k + 1));
            term = div_u64((term * x2) >> 30, div);
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        r = (longint'(sum) + 64'd32) >> 6;
        if (r > 64'd16777215)
            r = 64'd16777215;
        return r[Q_BITS-1:0];
    endfunction

    function automatic sine_tab_t build_sine_table();
        sine_tab_t tab;
        for (int unsigned i = 0; i < SINE_ENTRIES; i++)
        begin
            tab[i] = sine_q24(i);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage
`default_nettype wire

[rtl/core/agenv_sine_rom.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Quarter-wave sine table
// Constant table with one registered read port.
// ----------------------------------------------------------------------------
module agenv_sine_rom (
    input  wire logic                          clk,
    input  wire logic [agenv_pkg::SINE_ABITS-1:0] addr,
    output logic      [agenv_pkg::Q_BITS-1:0]     data
);
    import agenv_pkg::*;

    logic [Q_BITS-1:0] data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= SINE_TABLE[addr];
    end

    assign data = data_reg;

endmodule
`default_nettype wire

[rtl/core/agenv_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Envelope controller
// Sequences one sample word through region decode, progress, curve shaping
// and scaling on the datapath's shared multiplier.
// ----------------------------------------------------------------------------
module agenv_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        item_valid,
    input  wire logic [agenv_pkg::OP_W-1:0]  op,
    output logic                             item_stall,
    input  wire agenv_pkg::sts_t             sts,
    output agenv_pkg::cmd_t                  cmd
);
    import agenv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REGION,
        S_PROG,
        S_CLAMP,
        S_SQR,
        S_LO_RD,
        S_HI_RD,
        S_DELTA,
        S_INTERP,
        S_GAIN,
        S_SCALE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_PROG;
        case (state_reg)
            S_IDLE:
            begin
                cmd.capture = accept;
                if (accept && op == OP_SAMPLE)
                    state_next = S_REGION;
            end
            S_REGION:
            begin
                cmd.region_load = 1'b1;
                state_next      = S_PROG;
            end
            S_PROG:
            begin
                cmd.mul_sel  = MUL_PROG;
                cmd.mul_load = 1'b1;
                state_next   = sts.ramp ? S_CLAMP : S_GAIN;
            end
            S_CLAMP:
            begin
                cmd.clamp_load = 1'b1;
                case (sts.curve)
                    CURVE_LINEAR: state_next = S_GAIN;
                    CURVE_SINE:   state_next = S_LO_RD;
                    default:      state_next = S_SQR;
                endcase
            end
            S_SQR:
            begin
                cmd.mul_sel  = MUL_SQR;
                cmd.mul_load = 1'b1;
                state_next   = S_GAIN;
            end
            S_LO_RD:
            begin
                state_next = S_HI_RD;
            end
            S_HI_RD:
            begin
                cmd.rom_hi  = 1'b1;
                cmd.lo_load = 1'b1;
                state_next  = S_DELTA;
            end
            S_DELTA:
            begin
                cmd.delta_load = 1'b1;
                state_next     = S_INTERP;
            end
            S_INTERP:
            begin
                cmd.mul_sel  = MUL_INTERP;
                cmd.mul_load = 1'b1;
                state_next   = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.gain_load = 1'b1;
                state_next    = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.mul_sel  = MUL_SCALE;
                cmd.mul_load = 1'b1;
                state_next   = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // A sample word starts the sequence; other words finish in the accept cycle.
    a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && op == OP_SAMPLE) |=> state_reg == S_REGION)
        else $error("sample word did not start the envelope sequence");

    a_other_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && op != OP_SAMPLE) |=> state_reg == S_IDLE)
        else $error("non-sample word left the idle state");

    // A finished word waits while the output register is still held.
    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && sts.out_full) |=> state_reg == S_RESULT)
        else $error("result dropped while output register was full");

endmodule
`default_nettype wire

[rtl/core/agenv_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Envelope datapath
// Configuration and position registers, region decode, one shared
// multiplier, curve shaping, sine interpolation and the output register.
// ----------------------------------------------------------------------------
module agenv_datapath (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire agenv_pkg::cmd_t                      cmd,
    output agenv_pkg::sts_t                           sts,
    input  wire logic                                 wr_en,
    input  wire logic [agenv_pkg::CFG_IDX_W-1:0]      wr_index,
    input  wire logic [agenv_pkg::CFG_W-1:0]          wr_data,
    input  wire logic [agenv_pkg::OP_W-1:0]           op,
    input  wire logic signed [agenv_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic                                 last_channel,
    input  wire logic [agenv_pkg::POS_W-1:0]          advance_count,
    input  wire logic                                 result_stall,
    output logic                                      result_valid,
    output logic signed [agenv_pkg::SAMPLE_BITS-1:0]  sample_out,
    output logic                                      frame_end
);
    import agenv_pkg::*;

    typedef enum logic [1:0] {
        RGN_ZERO,
        RGN_ONE,
        RGN_ATTACK,
        RGN_RELEASE
    } region_t;

    // Configuration.
    logic [POS_W-1:0]   attack_start_reg;
    logic [LEN_W-1:0]   attack_length_reg;
    logic [RECIP_W-1:0] attack_recip_reg;
    logic [POS_W-1:0]   release_start_reg;
    logic [LEN_W-1:0]   release_length_reg;
    logic [RECIP_W-1:0] release_recip_reg;
    logic [CURVE_W-1:0] fade_curve_reg;

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   cur_reg;
    logic               neg_reg;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic               last_reg;
    region_t            region_reg;
    region_t            region_next;
    logic [LEN_W-1:0]   diff_reg;
    logic [LEN_W-1:0]   diff_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [GAIN_W-1:0]  c_reg;
    logic [GAIN_W-1:0]  c_next;
    logic [Q_BITS-1:0]  lo_reg;
    logic [GAIN_W-1:0]  delta_reg;
    logic [GAIN_W-1:0]  delta_next;
    logic [GAIN_W-1:0]  gain_reg;
    logic [GAIN_W-1:0]  gain_next;
    logic               result_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_out_reg;
    logic [SAMPLE_BITS-1:0] sample_out_next;
    logic               frame_end_reg;

    logic [SAMPLE_BITS-1:0] mag_in;
    logic [POS_W:0]     cur_x;
    logic [POS_W:0]     a_start_x;
    logic [POS_W:0]     a_end_x;
    logic [POS_W:0]     r_start_x;
    logic [POS_W:0]     r_end_x;
    logic               attack_on;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [PROD_W-1:0]  prod_next;
    logic [PROD_W-1:0]  prod_rnd;
    logic [PROD_W-Q_BITS-1:0] rnd;
    logic [GAIN_W-1:0]  c_prog;
    logic [SINE_ABITS-1:0] sine_idx;
    logic [Q_BITS-1:0]  sine_frac;
    logic               sine_ovf;
    logic [SINE_ABITS-1:0] rom_addr;
    logic [Q_BITS-1:0]  rom_data;
    logic [GAIN_W-1:0]  hi_val;
    logic [GAIN_W-1:0]  lo_x;

    // ------------------------------------------------------------------
    // Configuration and position.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_start_reg   <= '0;
            attack_length_reg  <= '0;
            attack_recip_reg   <= '0;
            release_start_reg  <= '0;
            release_length_reg <= '0;
            release_recip_reg  <= '0;
            fade_curve_reg     <= CURVE_SQUARED;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_ATTACK_START:   attack_start_reg   <= wr_data[POS_W-1:0];
                REG_ATTACK_LENGTH:  attack_length_reg  <= wr_data[LEN_W-1:0];
                REG_ATTACK_RECIP:   attack_recip_reg   <= wr_data[RECIP_W-1:0];
                REG_RELEASE_START:  release_start_reg  <= wr_data[POS_W-1:0];
                REG_RELEASE_LENGTH: release_length_reg <= wr_data[LEN_W-1:0];
                REG_RELEASE_RECIP:  release_recip_reg  <= wr_data[RECIP_W-1:0];
                REG_FADE_CURVE:     fade_curve_reg     <= wr_data[CURVE_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (cmd.capture)
        begin
            case (op)
                OP_SAMPLE:
                begin
                    if (last_channel)
                        pos_reg <= pos_reg + POS_W'(1);
                end
                OP_ADVANCE: pos_reg <= pos_reg + advance_count;
                OP_RESTART: pos_reg <= '0;
                default:    ;
            endcase
        end
    end

    // The gain uses the frame number before this word moves the position.
    assign mag_in = sample_in[SAMPLE_BITS-1] ? (~sample_in + SAMPLE_BITS'(1)) : sample_in;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cur_reg  <= pos_reg + POS_W'(1);
            neg_reg  <= sample_in[SAMPLE_BITS-1];
            mag_reg  <= mag_in;
            last_reg <= last_channel;
        end
    end

    // ------------------------------------------------------------------
    // Region decode. Boundary sums are one bit wider so they never wrap.
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_x     = {1'b0, cur_reg};
        a_start_x = {1'b0, attack_start_reg};
        r_start_x = {1'b0, release_start_reg};
        a_end_x   = a_start_x + (POS_W+1)'(attack_length_reg);
        r_end_x   = r_start_x + (POS_W+1)'(release_length_reg);
        attack_on = (attack_length_reg != '0);

        region_next = RGN_RELEASE;
        diff_next   = cur_reg[LEN_W-1:0] - release_start_reg[LEN_W-1:0];
        if (attack_on && cur_x <= a_start_x)
            region_next = RGN_ZERO;
        else if (attack_on && cur_x < a_end_x)
        begin
            region_next = RGN_ATTACK;
            diff_next   = cur_reg[LEN_W-1:0] - attack_start_reg[LEN_W-1:0];
        end
        else if (cur_x < r_start_x)
            region_next = RGN_ONE;
        else if (cur_x > r_end_x)
            region_next = RGN_ZERO;
    end

    // ------------------------------------------------------------------
    // Shared multiplier.
    // ------------------------------------------------------------------
    assign sine_idx  = c_reg[Q_BITS-1 -: SINE_ABITS];
    assign sine_frac = {c_reg[Q_BITS-SINE_ABITS-1:0], {SINE_ABITS{1'b0}}};
    assign sine_ovf  = c_reg[Q_BITS];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_PROG:
            begin
                mul_a = MUL_W'(diff_reg);
                mul_b = (region_reg == RGN_ATTACK) ? MUL_W'(attack_recip_reg)
                                                   : MUL_W'(release_recip_reg);
            end
            MUL_SQR:
            begin
                mul_a = MUL_W'(c_reg);
                mul_b = MUL_W'(c_reg);
            end
            MUL_INTERP:
            begin
                mul_a = MUL_W'(delta_reg);
                mul_b = MUL_W'(sine_frac);
            end
            MUL_SCALE:
            begin
                mul_a = MUL_W'(mag_reg);
                mul_b = MUL_W'(gain_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign prod_rnd = prod_reg + PROD_W'(HALF_Q24);
    assign rnd      = prod_rnd[PROD_W-1:Q_BITS];

    // Progress saturates at one; the release ramp runs from one down.
    always_comb
    begin
        c_prog = (prod_reg > PROD_W'(ONE_Q24)) ? ONE_Q24 : prod_reg[GAIN_W-1:0];
        c_next = (region_reg == RGN_RELEASE) ? (ONE_Q24 - c_prog) : c_prog;
    end

    // ------------------------------------------------------------------
    // Sine interpolation. The entry past the last one is exactly one.
    // ------------------------------------------------------------------
    assign rom_addr = cmd.rom_hi ? (sine_idx + SINE_ABITS'(1)) : sine_idx;

    agenv_sine_rom u_sine_rom (
        .clk  (clk),
        .addr (rom_addr),
        .data (rom_data)
    );

    always_comb
    begin
        lo_x   = {1'b0, lo_reg};
        hi_val = (sine_idx == SINE_ABITS'(SINE_ENTRIES - 1)) ? ONE_Q24 : {1'b0, rom_data};
        delta_next = (hi_val < lo_x) ? '0 : (hi_val - lo_x);
    end

    // ------------------------------------------------------------------
    // Gain and result.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (region_reg)
            RGN_ZERO: gain_next = '0;
            RGN_ONE:  gain_next = ONE_Q24;
            default:
            begin
                case (fade_curve_reg)
                    CURVE_LINEAR: gain_next = c_reg;
                    CURVE_SINE:   gain_next = sine_ovf ? ONE_Q24
                                                       : (lo_x + rnd[GAIN_W-1:0]);
                    default:      gain_next = rnd[GAIN_W-1:0];
                endcase
            end
        endcase
    end

    assign sample_out_next = neg_reg ? (~rnd[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                                     : rnd[SAMPLE_BITS-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.region_load)
        begin
            region_reg <= region_next;
            diff_reg   <= diff_next;
        end
        if (cmd.mul_load)
            prod_reg <= prod_next;
        if (cmd.clamp_load)
            c_reg <= c_next;
        if (cmd.lo_load)
            lo_reg <= rom_data;
        if (cmd.delta_load)
            delta_reg <= delta_next;
        if (cmd.gain_load)
            gain_reg <= gain_next;
        if (cmd.out_load)
        begin
            sample_out_reg <= sample_out_next;
            frame_end_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (cmd.out_load)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign frame_end    = frame_end_reg;

    assign sts.ramp     = (region_reg == RGN_ATTACK) || (region_reg == RGN_RELEASE);
    assign sts.curve    = fade_curve_reg;
    assign sts.out_full = result_valid_reg && result_stall;

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.gain_load |=> gain_reg <= ONE_Q24)
        else $error("envelope gain above unity");

    a_pos_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && op == OP_SAMPLE && last_channel)
            |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("position did not step after the last channel");

    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.capture && op == OP_RESTART) |=> pos_reg == '0)
        else $error("position not cleared on restart");

endmodule
`default_nettype wire

[rtl/core/attack_release_gain_envelope_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Attack/release gain envelope
// Scales audio samples by an attack/release volume envelope that follows a
// frame position counter, with squared, linear or constant power ramps.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Word
//  item     in         item_valid/item_stall     op, sample_in, last_channel,
//                                                advance_count
//  result   out        result_valid/result_stall sample_out, frame_end
//  config   in         wr_en                     wr_index, wr_data
//
//  A sample word steps through more controller states on a ramp than in the
//  silent and pass-through regions, and most on a constant power ramp;
//  advance and restart words finish in the accept cycle. No new word is taken
//  until the last one is through, as the controller steps the single shared
//  multiplier and the single read port of the sine table through in turn.
//  Reset clears the position and all configuration registers to zero.
//  A finished word sits in the output register; a stalled result holds the
//  next sample word in its last step until the register is free.
// ----------------------------------------------------------------------------
module attack_release_gain_envelope_top (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     wr_en,
    input  wire logic [agenv_pkg::CFG_IDX_W-1:0]          wr_index,
    input  wire logic [agenv_pkg::CFG_W-1:0]              wr_data,
    input  wire logic                                     item_valid,
    output logic                                          item_stall,
    input  wire logic [agenv_pkg::OP_W-1:0]               op,
    input  wire logic signed [agenv_pkg::SAMPLE_BITS-1:0] sample_in,
    input  wire logic                                     last_channel,
    input  wire logic [agenv_pkg::POS_W-1:0]              advance_count,
    output logic                                          result_valid,
    input  wire logic                                     result_stall,
    output logic signed [agenv_pkg::SAMPLE_BITS-1:0]      sample_out,
    output logic                                          frame_end
);
    import agenv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    agenv_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .op         (op),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    agenv_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .op            (op),
        .sample_in     (sample_in),
        .last_channel  (last_channel),
        .advance_count (advance_count),
        .result_stall  (result_stall),
        .result_valid  (result_valid),
        .sample_out    (sample_out),
        .frame_end     (frame_end)
    );

endmodule
`default_nettype wire

[dv/attack_release_gain_envelope_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Attack/release gain envelope testbench
// Drives sample, advance and restart words through the item channel under
// random idling on both sides. A predictor tracks the frame position and the
// register settings and computes each scaled sample. Every result word is
// compared with the oldest predicted word. Directed words cover the sample
// extremes and the corner cases. Random words then jump to the envelope
// boundaries and walk frames across them under changing settings.
// ----------------------------------------------------------------------------
module attack_release_gain_envelope_top_test;

    import agenv_pkg::*;

    localparam int SB            = SAMPLE_BITS;
    localparam int SINE_N        = SINE_ENTRIES;
    localparam int IDLE_PCT      = 23;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;
    localparam int RANDOM_WORDS  = 1080;

    localparam bit [63:0] GAIN_UNITY       = 64'd16777216;
    localparam bit [63:0] GAIN_HALF        = 64'd8388608;
    localparam bit [63:0] QUARTER_TURN_Q30 = 64'd1686629713;

    // Codes that the block must ignore or treat as another code.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [CURVE_W-1:0]   CURVE_ALIAS = 2'd3;
    localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [SB-1:0] sample_out;
        logic          frame_end;
    } scaled_word_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 wr_en         = 1'b0;
    logic [CFG_IDX_W-1:0] wr_index      = '0;
    logic [CFG_W-1:0]     wr_data       = '0;
    logic                 item_valid    = 1'b0;
    logic                 item_stall;
    logic [OP_W-1:0]      op            = OP_SAMPLE;
    logic signed [SB-1:0] sample_in     = '0;
    logic                 last_channel  = 1'b0;
    logic [POS_W-1:0]     advance_count = '0;
    logic                 result_valid;
    logic                 result_stall  = 1'b0;
    logic signed [SB-1:0] sample_out;
    logic                 frame_end;

    // Predictor copy of the registers and the position.
    bit [POS_W-1:0]   atk_start;
    bit [LEN_W-1:0]   atk_len;
    bit [RECIP_W-1:0] atk_recip;
    bit [POS_W-1:0]   rel_start;
    bit [LEN_W-1:0]   rel_len;
    bit [RECIP_W-1:0] rel_recip;
    bit [CURVE_W-1:0] curve;
    bit [POS_W-1:0]   frame_pos;
    bit [Q_BITS-1:0]  quarter_sine [SINE_N];

    scaled_word_t pending_words [$];
    int           error_count  = 0;
    int           words_sent   = 0;
    int           quiet_cycles = 0;
    bit           calm         = 1'b0;

    attack_release_gain_envelope_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_index      (wr_index),
        .wr_data       (wr_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .op            (op),
        .sample_in     (sample_in),
        .last_channel  (last_channel),
        .advance_count (advance_count),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .sample_out    (sample_out),
        .frame_end     (frame_end)
    );

    always #5 clk = ~clk;

    // Quarter sine in Q0.24 from a Taylor series in Q30.
    function automatic bit [Q_BITS-1:0] sine_entry(int unsigned idx);
        bit [63:0] angle;
        bit [63:0] angle_sq;
        bit [63:0] term;
        bit [63:0] rounded;
        longint    acc;
        int        k;
        angle    = ({32'd0, idx} * QUARTER_TURN_Q30) / SINE_N;
        angle_sq = (angle * angle) >> 30;
        term     = angle;
        acc      = $signed(angle);
        for (k = 1; k <= 7; k++)
        begin
            term = ((term * angle_sq) >> 30) / (2 * k * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - $signed(term);
            else
                acc = acc + $signed(term);
        end
        if (acc < 0)
            acc = 0;
        rounded = acc;
        rounded = (rounded + 64'd32) >> 6;
        if (rounded > 64'd16777215)
            rounded = 64'd16777215;
        return rounded[Q_BITS-1:0];
    endfunction

    function automatic bit [63:0] ramp_progress(bit [63:0] diff, bit [RECIP_W-1:0] recip);
        bit [63:0] prod;
        prod = diff * {39'd0, recip};
        return (prod > GAIN_UNITY) ? GAIN_UNITY : prod;
    endfunction

    function automatic bit [63:0] ramp_shape(bit [63:0] c);
        bit [63:0] scaled;
        bit [63:0] idx;
        bit [63:0] frac;
        bit [63:0] lo;
        bit [63:0] hi;
        case (curve)
            CURVE_LINEAR:
                return c;
            CURVE_SINE:
            begin
                scaled = c * SINE_N;
                idx    = scaled >> 24;
                frac   = scaled & (GAIN_UNITY - 64'd1);
                if (idx >= SINE_N)
                    return GAIN_UNITY;
                lo = quarter_sine[idx];
                hi = (idx + 1 < SINE_N) ? quarter_sine[idx + 1] : GAIN_UNITY;
                if (hi < lo)
                    hi = lo;
                return lo + (((hi - lo) * frac + GAIN_HALF) >> 24);
            end
            // The unused curve code falls back to squared.
            default:
                return (c * c + GAIN_HALF) >> 24;
        endcase
    endfunction

    function automatic bit [63:0] envelope_gain();
        bit [31:0] cur32;
        bit [63:0] cur;
        bit [63:0] atk_end;
        bit [63:0] rel_end;
        cur32   = frame_pos + 32'd1;
        cur     = {32'd0, cur32};
        atk_end = {32'd0, atk_start} + {40'd0, atk_len};
        rel_end = {32'd0, rel_start} + {40'd0, rel_len};
        if (atk_len != 0 && cur <= atk_start)
            return 64'd0;
        if (atk_len != 0 && cur < atk_end)
            return ramp_shape(ramp_progress(cur - atk_start, atk_recip));
        if (cur < rel_start)
            return GAIN_UNITY;
        if (cur > rel_end)
            return 64'd0;
        return ramp_shape(GAIN_UNITY - ramp_progress(cur - rel_start, rel_recip));
    endfunction

    // Magnitude times gain, rounded half away from zero, sign restored.
    function automatic logic [SB-1:0] scale_sample(logic [SB-1:0] raw, bit [63:0] gain);
        logic [SB-1:0] neg_raw;
        bit [63:0]     mag;
        bit [63:0]     prod;
        neg_raw = ~raw + 1'b1;
        mag     = raw[SB-1] ? {{(64-SB){1'b0}}, neg_raw} : {{(64-SB){1'b0}}, raw};
        prod    = (mag * gain + GAIN_HALF) >> 24;
        if (raw[SB-1])
            prod = ~prod + 64'd1;
        return prod[SB-1:0];
    endfunction

    function automatic void predict_word(logic [OP_W-1:0] code, logic [SB-1:0] sample,
                                         logic last, logic [POS_W-1:0] count);
        scaled_word_t word;
        case (code)
            OP_ADVANCE:
                frame_pos = frame_pos + count;
            OP_RESTART:
                frame_pos = '0;
            OP_SAMPLE:
            begin
                word.sample_out = scale_sample(sample, envelope_gain());
                word.frame_end  = last;
                pending_words   = {pending_words, word};
                if (last)
                    frame_pos = frame_pos + 32'd1;
            end
            default:
                ;
        endcase
    endfunction

    function automatic logic [SB-1:0] rand_sample();
        case ($urandom_range(0, 11))
            0:       return {1'b0, {(SB-1){1'b1}}};
            1:       return {1'b1, {(SB-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return SB'($urandom);
        endcase
    endfunction

    function automatic bit [RECIP_W-1:0] recip_for(bit [LEN_W-1:0] len);
        bit [63:0] q;
        if (len == 0)
            return '0;
        q = (GAIN_UNITY + len / 2) / len;
        return q[RECIP_W-1:0];
    endfunction

    // Result side: a word is taken at the edge after a negedge that shows
    // valid high and stall low.
    always @(negedge clk)
    begin
        scaled_word_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_words.size() == 0)
            begin
                $error("sample_out: no word pending, got %0d", sample_out);
                error_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (sample_out !== want.sample_out)
                begin
                    $error("sample_out: expected %0d, got %0d",
                           $signed(want.sample_out), sample_out);
                    error_count++;
                end
                if (frame_end !== want.frame_end)
                begin
                    $error("frame_end: expected %0d, got %0d", want.frame_end, frame_end);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
        result_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);

    always @(negedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        case (idx)
            REG_ATTACK_START:   atk_start = data;
            REG_ATTACK_LENGTH:  atk_len   = data[LEN_W-1:0];
            REG_ATTACK_RECIP:   atk_recip = data[RECIP_W-1:0];
            REG_RELEASE_START:  rel_start = data;
            REG_RELEASE_LENGTH: rel_len   = data[LEN_W-1:0];
            REG_RELEASE_RECIP:  rel_recip = data[RECIP_W-1:0];
            REG_FADE_CURVE:     curve     = data[CURVE_W-1:0];
            default:            ;
        endcase
    endtask

    // Writes every register; now and then the bits above a short register
    // carry junk that the block has to drop.
    task automatic load_envelope(input bit [31:0] a_start, input bit [23:0] a_len,
                                 input bit [24:0] a_recip, input bit [31:0] r_start,
                                 input bit [23:0] r_len, input bit [24:0] r_recip,
                                 input bit [1:0] ramp_kind);
        bit [31:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? $urandom : 32'd0;
        write_reg(REG_ATTACK_START, a_start);
        write_reg(REG_ATTACK_LENGTH, {junk[31:24], a_len});
        write_reg(REG_ATTACK_RECIP, {junk[31:25], a_recip});
        write_reg(REG_RELEASE_START, r_start);
        write_reg(REG_RELEASE_LENGTH, {junk[31:24], r_len});
        write_reg(REG_RELEASE_RECIP, {junk[31:25], r_recip});
        write_reg(REG_FADE_CURVE, {junk[31:2], ramp_kind});
        wr_en <= 1'b0;
    endtask

    // Waits until every predicted word has come back and the block is idle.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_word(input logic [OP_W-1:0] code, input logic [SB-1:0] sample,
                             input logic last, input logic [POS_W-1:0] count);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        op            <= code;
        sample_in     <= sample;
        last_channel  <= last;
        advance_count <= count;
        @(negedge clk);
        while (item_stall)
            @(negedge clk);
        @(posedge clk);
        predict_word(code, sample, last, count);
        if (code != OP_RESERVED)
            words_sent++;
    endtask

    task automatic move_to_frame(input bit [31:0] frame);
        bit [31:0] target;
        target = frame - 32'd1;
        if ($urandom_range(0, 3) == 0)
        begin
            send_word(OP_RESTART, rand_sample(), 1'($urandom), $urandom);
            send_word(OP_ADVANCE, rand_sample(), 1'($urandom), target);
        end
        else
            send_word(OP_ADVANCE, rand_sample(), 1'($urandom), target - frame_pos);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:       send_word(OP_RESERVED, rand_sample(), 1'($urandom), $urandom);
            1:       send_word(OP_ADVANCE, rand_sample(), 1'($urandom), $urandom);
            default: send_word(OP_RESTART, rand_sample(), 1'($urandom), $urandom);
        endcase
    endtask

    task automatic walk_frames(input int frames);
        int channels;
        for (int f = 0; f < frames; f++)
        begin
            channels = $urandom_range(1, 3);
            for (int ch = 0; ch < channels; ch++)
            begin
                if ($urandom_range(0, 11) == 0)
                    send_noise();
                send_word(OP_SAMPLE, rand_sample(), ch == channels - 1, $urandom);
            end
        end
    endtask

    // All registers are zero after reset, so every frame is past the release.
    task automatic test_reset_state();
        send_word(OP_SAMPLE, {1'b0, {(SB-1){1'b1}}}, 1'b1, '1);
        send_word(OP_SAMPLE, {1'b1, {(SB-1){1'b0}}}, 1'b0, '0);
    endtask

    task automatic test_pass_through();
        settle();
        write_reg(REG_UNUSED, $urandom);
        load_envelope('0, '0, '0, '1, '0, '0, CURVE_LINEAR);
        send_word(OP_SAMPLE, {1'b0, {(SB-1){1'b1}}}, 1'b0, '1);
        send_word(OP_SAMPLE, {1'b1, {(SB-1){1'b0}}}, 1'b1, '0);
        send_word(OP_SAMPLE, '0, 1'b0, $urandom);
        send_word(OP_SAMPLE, '1, 1'b1, $urandom);
        send_word(OP_SAMPLE, SB'(1), 1'b1, $urandom);
        send_word(OP_RESERVED, rand_sample(), 1'b1, 32'd3);
        send_word(OP_ADVANCE, rand_sample(), 1'b0, 32'd5);
        send_word(OP_RESTART, rand_sample(), 1'b1, '1);
        send_word(OP_SAMPLE, rand_sample(), 1'b1, $urandom);
    endtask

    // Oversized attack reciprocal, the unused curve code, a zero release
    // length at its boundary frame, and the position wrapping on advance.
    task automatic test_special_cases();
        settle();
        load_envelope(32'd10, 24'd4, '1, 32'd20, '0, '0, CURVE_ALIAS);
        move_to_frame(32'd11);
        send_word(OP_SAMPLE, {1'b0, {(SB-1){1'b1}}}, 1'b1, $urandom);
        send_word(OP_SAMPLE, {1'b1, {(SB-1){1'b0}}}, 1'b1, $urandom);
        move_to_frame(32'd19);
        send_word(OP_SAMPLE, rand_sample(), 1'b1, $urandom);
        send_word(OP_SAMPLE, {1'b1, {(SB-1){1'b0}}}, 1'b1, $urandom);
        send_word(OP_SAMPLE, rand_sample(), 1'b1, $urandom);
        send_word(OP_ADVANCE, rand_sample(), 1'b0, '1);
        send_word(OP_SAMPLE, rand_sample(), 1'b1, $urandom);
        move_to_frame(32'd0);
        send_word(OP_SAMPLE, {1'b0, {(SB-1){1'b1}}}, 1'b0, $urandom);
    endtask

    task automatic test_random_envelopes();
        int        first;
        int        phase;
        int        runs;
        bit [31:0] a_start;
        bit [31:0] r_start;
        bit [31:0] frame;
        bit [31:0] offset;
        bit [23:0] a_len;
        bit [23:0] r_len;
        bit [24:0] a_recip;
        bit [24:0] r_recip;
        first = words_sent;
        phase = 0;
        while (words_sent - first < RANDOM_WORDS)
        begin
            settle();
            calm    = (phase == 6);
            a_start = $urandom;
            a_len   = 24'($urandom_range(1, 48));
            r_len   = 24'($urandom_range(0, 48));
            r_start = a_start + a_len + $urandom_range(0, 16);
            if ($urandom_range(0, 3) == 0)
                r_start = $urandom;
            // The first phases pin the register extremes.
            case (phase)
                0:
                begin
                    a_start = '0;
                    a_len   = '1;
                    r_start = '1;
                    r_len   = '0;
                end
                1:
                begin
                    a_len   = '0;
                    r_start = '0;
                    r_len   = '1;
                end
                2:
                begin
                    a_start = '1;
                    r_start = '1;
                    r_len   = '1;
                end
                default:
                    ;
            endcase
            a_recip = recip_for(a_len);
            r_recip = recip_for(r_len);
            case ($urandom_range(0, 15))
                0:       a_recip = 25'($urandom);
                1:       r_recip = 25'($urandom);
                2:       a_recip = '0;
                3:       r_recip = '1;
                default: ;
            endcase
            load_envelope(a_start, a_len, a_recip, r_start, r_len, r_recip, phase[1:0]);
            runs = $urandom_range(3, 6);
            repeat (runs)
            begin
                offset = $urandom_range(0, 6) - 32'd3;
                case ($urandom_range(0, 4))
                    0: frame = atk_start + offset;
                    1: frame = atk_start + atk_len + offset;
                    2: frame = rel_start + offset;
                    3: frame = rel_start + rel_len + offset;
                    default:
                    begin
                        if ($urandom_range(0, 1) == 0)
                            frame = atk_start + $urandom_range(0, atk_len);
                        else
                            frame = rel_start + $urandom_range(0, rel_len);
                    end
                endcase
                move_to_frame(frame);
                walk_frames($urandom_range(1, 10));
            end
            calm = 1'b0;
            phase++;
        end
    endtask

    initial
    begin
        for (int unsigned i = 0; i < SINE_N; i++)
            quarter_sine[i] = sine_entry(i);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_pass_through();
        test_special_cases();
        test_random_envelopes();
        settle();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
